### design/sqrs_pkg.sv
// ----------------------------------------------------------------------------
// sqrs_pkg
// Shared types and constants of the slope QRS detector.
// ----------------------------------------------------------------------------
package sqrs_pkg;

	// Default widths of the sample and of the running sample index
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int INDEX_WIDTH_DEF  = 32;

	// Register field widths
	localparam int FLOOR_WIDTH  = 16;
	localparam int WINDOW_WIDTH = 10;
	localparam int PERIOD_WIDTH = 16;
	localparam int CFG_WIDTH    = 16;
	localparam int CFG_ADDR_W   = 2;

	// Threshold holds up to ten times the floor
	localparam int THR_WIDTH = FLOOR_WIDTH + 4;

	// Number of past samples kept for the slope filter
	localparam int TAPS = 9;

	// Reversal count: width, saturation and decision points
	localparam int          CNT_WIDTH = 3;
	localparam logic [2:0]  CNT_MAX   = 3'd7;
	localparam logic [2:0]  CNT_LONG  = 3'd4;
	localparam logic [2:0]  CNT_ART   = 3'd5;
	localparam logic [2:0]  CNT_BEAT  = 3'd2;

	// Register reset values
	localparam logic [FLOOR_WIDTH-1:0]  FLOOR_RST  = 16'd200;
	localparam logic [WINDOW_WIDTH-1:0] SHORT_RST  = 10'd40;
	localparam logic [WINDOW_WIDTH-1:0] LONG_RST   = 10'd50;
	localparam logic [PERIOD_WIDTH-1:0] PERIOD_RST = 16'd500;

	// Register indexes of the configuration port
	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_FLOOR  = 2'd0,
		REG_SHORT  = 2'd1,
		REG_LONG   = 2'd2,
		REG_PERIOD = 2'd3
	} cfg_reg_t;

	// Result kind
	typedef enum logic {
		KIND_NORMAL   = 1'b0,
		KIND_ARTIFACT = 1'b1
	} beat_kind_t;

endpackage

### design/slope_qrs_detector.sv
// ----------------------------------------------------------------------------
// slope_qrs_detector
// Slope-based QRS detector: ten-tap slope filter, adaptive threshold,
// reversal counting in a time window, at most one beat or artifact per slope.
// ----------------------------------------------------------------------------
//
//  channel | signals                                  | moves on
//  --------+------------------------------------------+------------------------
//  in      | in_valid, in_ready, sample               | in_valid & in_ready
//  out     | out_valid, out_ready, beat_position,     | out_valid & out_ready
//          | beat_kind                                |
//  cfg     | cfg_write, cfg_index, cfg_data           | cfg_write
//
// An accepted request lands in the input register; from there the whole
// per-sample update (filter, threshold, window, index) completes in a single
// combinational pass and, when the input register advances, its result, if
// any, lands in the output register. One sample per cycle is sustained
// while out_ready stays high. A full output register that is not taken
// holds the input register, and in_ready drops only then. Reset clears
// all state but the sample and result data, and loads register defaults.
//
module slope_qrs_detector #(
	parameter int SAMPLE_WIDTH = sqrs_pkg::SAMPLE_WIDTH_DEF,
	parameter int INDEX_WIDTH  = sqrs_pkg::INDEX_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_write,
	input  logic [sqrs_pkg::CFG_ADDR_W-1:0]       cfg_index,
	input  logic [sqrs_pkg::CFG_WIDTH-1:0]        cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]        sample,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [INDEX_WIDTH:0]           beat_position,
	output logic                                  beat_kind
);
	import sqrs_pkg::*;

	// Slope filter gain sum is 32, so six extra bits
	localparam int FW = SAMPLE_WIDTH + 6;
	// Working width for threshold arithmetic, wide enough for slope and 17/16 growth
	localparam int WW = (FW + 2 > THR_WIDTH + 4) ? FW + 2 : THR_WIDTH + 4;
	localparam int WIN_W = WINDOW_WIDTH + 1;

	// Configuration registers
	logic [FLOOR_WIDTH-1:0]  floor_q;
	logic [WINDOW_WIDTH-1:0] short_q;
	logic [WINDOW_WIDTH-1:0] long_q;
	logic [PERIOD_WIDTH-1:0] period_q;

	// Input register
	logic                           valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] sample_s1;

	// Detector state
	logic signed [SAMPLE_WIDTH-1:0] dl_q [TAPS];
	logic                           primed_q;
	logic [THR_WIDTH-1:0]           thr_q;
	logic [CNT_WIDTH-1:0]           cnt_q;
	logic [FW-1:0]                  peak_q;
	logic                           pol_q;
	logic signed [WIN_W-1:0]        win_q;
	logic [PERIOD_WIDTH-1:0]        phase_q;
	logic [INDEX_WIDTH-1:0]         onset_q;
	logic [INDEX_WIDTH-1:0]         index_q;

	// Output register
	logic                     out_valid_q;
	logic [INDEX_WIDTH:0]     pos_q;
	beat_kind_t               kind_q;

	logic advance;

	// Combinational update
	logic signed [FW-1:0]           tap_w [TAPS];
	logic signed [FW-1:0]           x0_w;
	logic signed [FW-1:0]           slope;
	logic signed [FW-1:0]           slope_abs;
	logic signed [WW-1:0]           af_w;
	logic signed [WW-1:0]           lo_w;
	logic signed [WW-1:0]           hi_w;
	logic [THR_WIDTH-1:0]           hi_t;
	logic signed [WW-1:0]           thr0;
	logic signed [WW-1:0]           thr1;
	logic signed [WW-1:0]           thr2;
	logic signed [WW-1:0]           adj;
	logic signed [WW-1:0]           along;
	logic                           open_slope;
	logic [CNT_WIDTH-1:0]           cnt1;
	logic [CNT_WIDTH-1:0]           cnt_n;
	logic                           pol1;
	logic                           pol_n;
	logic signed [WIN_W-1:0]        win1;
	logic signed [WIN_W-1:0]        win_n;
	logic [INDEX_WIDTH-1:0]         onset_n;
	logic [FW-1:0]                  peak_n;
	logic                           restart;
	logic                           produce;
	beat_kind_t                     kind_n;
	logic [PERIOD_WIDTH-1:0]        phase_r;
	logic [PERIOD_WIDTH:0]          phase_inc;
	logic [PERIOD_WIDTH-1:0]        phase_n;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_comb begin
		// Fill the line from the first sample
		x0_w = FW'(sample_s1);
		for (int i = 0; i < TAPS; i++) begin
			tap_w[i] = primed_q ? FW'(dl_q[i]) : x0_w;
		end
		slope = x0_w + (tap_w[0] <<< 2) + (tap_w[1] <<< 2) + (tap_w[1] <<< 1)
			+ (tap_w[2] <<< 2) + tap_w[3] - tap_w[4] - (tap_w[5] <<< 2)
			- (tap_w[6] <<< 2) - (tap_w[6] <<< 1) - (tap_w[7] <<< 2) - tap_w[8];
		slope_abs = slope[FW-1] ? -slope : slope;
		af_w = WW'(slope_abs);

		// Floor and ceiling follow the register live
		hi_t = (THR_WIDTH'(floor_q) << 3) + (THR_WIDTH'(floor_q) << 1);
		lo_w = WW'(floor_q);
		hi_w = WW'(hi_t);
		thr0 = primed_q ? WW'(thr_q) : hi_w;

		// Periodic decay or growth
		thr1 = thr0;
		if (phase_q == '0) begin
			if (cnt_q == '0) begin
				thr1 = thr0 - (thr0 >>> 4);
				if (thr1 < lo_w) thr1 = lo_w;
			end else if (cnt_q >= CNT_ART) begin
				thr1 = thr0 + (thr0 >>> 4);
				if (thr1 > hi_w) thr1 = hi_w;
			end
		end

		// Open a slope
		open_slope = (cnt_q == '0) && (af_w > thr1);
		cnt1    = open_slope ? CNT_WIDTH'(1) : cnt_q;
		win1    = open_slope ? WIN_W'(short_q) : win_q;
		pol1    = open_slope ? (slope <= 0) : pol_q;
		onset_n = open_slope ? index_q : onset_q;

		cnt_n   = cnt1;
		pol_n   = pol1;
		win_n   = win1;
		peak_n  = peak_q;
		thr2    = thr1;
		adj     = '0;
		restart = 1'b0;
		produce = 1'b0;
		kind_n  = KIND_NORMAL;
		along   = pol1 ? -WW'(slope) : WW'(slope);

		if (cnt1 != '0) begin
			if (along < -thr1) begin
				// Reversal: flip, count, reload the window
				pol_n = !pol1;
				if (cnt1 < CNT_MAX) cnt_n = cnt1 + CNT_WIDTH'(1);
				win_n = (cnt_n > CNT_LONG) ? WIN_W'(long_q) : WIN_W'(short_q);
			end else if (along > thr1 && af_w > WW'(peak_q)) begin
				peak_n = slope_abs[FW-1:0];
			end
			if (win_n < 0) begin
				// Window expired: classify
				if (cnt_n >= CNT_BEAT && cnt_n <= CNT_LONG) begin
					// Signed shift rounds the step toward minus infinity
					adj = (($signed(WW'(peak_n)) >>> 2) - thr1) >>> 3;
					thr2 = thr1 + adj;
					if (thr2 < lo_w) thr2 = lo_w;
					if (thr2 > hi_w) thr2 = hi_w;
					produce = 1'b1;
					kind_n  = KIND_NORMAL;
					restart = 1'b1;
				end else if (cnt_n >= CNT_ART) begin
					produce = 1'b1;
					kind_n  = KIND_ARTIFACT;
				end
				cnt_n = '0;
			end else begin
				win_n = win_n - WIN_W'(1);
			end
		end

		// Wrapping phase counter
		phase_r   = restart ? '0 : phase_q;
		phase_inc = {1'b0, phase_r} + (PERIOD_WIDTH+1)'(1);
		phase_n   = (phase_inc >= {1'b0, period_q}) ? '0 : phase_inc[PERIOD_WIDTH-1:0];
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			floor_q  <= FLOOR_RST;
			short_q  <= SHORT_RST;
			long_q   <= LONG_RST;
			period_q <= PERIOD_RST;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FLOOR:  floor_q  <= cfg_data[FLOOR_WIDTH-1:0];
				REG_SHORT:  short_q  <= cfg_data[WINDOW_WIDTH-1:0];
				REG_LONG:   long_q   <= cfg_data[WINDOW_WIDTH-1:0];
				REG_PERIOD: period_q <= cfg_data[PERIOD_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sample_s1 <= sample;
		end
	end

	// Detector state: advance once per sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				dl_q[i] <= '0;
			end
			primed_q <= 1'b0;
			thr_q    <= '0;
			cnt_q    <= '0;
			peak_q   <= '0;
			pol_q    <= 1'b0;
			win_q    <= '0;
			phase_q  <= '0;
			onset_q  <= '0;
			index_q  <= '0;
		end else if (advance) begin
			dl_q[0] <= sample_s1;
			for (int i = 1; i < TAPS; i++) begin
				dl_q[i] <= tap_w[i-1][SAMPLE_WIDTH-1:0];
			end
			primed_q <= 1'b1;
			thr_q    <= thr2[THR_WIDTH-1:0];
			cnt_q    <= cnt_n;
			peak_q   <= peak_n;
			pol_q    <= pol_n;
			win_q    <= win_n;
			phase_q  <= phase_n;
			onset_q  <= onset_n;
			index_q  <= index_q + INDEX_WIDTH'(1);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= produce;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && produce) begin
			// Onset minus three, in one extra bit so early onsets go negative
			pos_q  <= {1'b0, onset_n} - (INDEX_WIDTH+1)'(3);
			kind_q <= kind_n;
		end
	end

	assign out_valid     = out_valid_q;
	assign beat_position = pos_q;
	assign beat_kind     = kind_q;

endmodule

### design/sqrs_checker.sv
// ----------------------------------------------------------------------------
// sqrs_checker
// Port-level checks of the slope QRS detector, bound to the top level.
// ----------------------------------------------------------------------------
module sqrs_checker #(
	parameter int SAMPLE_WIDTH = sqrs_pkg::SAMPLE_WIDTH_DEF,
	parameter int INDEX_WIDTH  = sqrs_pkg::INDEX_WIDTH_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic signed [SAMPLE_WIDTH-1:0]  sample,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic signed [INDEX_WIDTH:0]     beat_position,
	input logic                            beat_kind
);
	import sqrs_pkg::*;

	// Hold a waiting request
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(sample))
	else $error("waiting request changed");

	// Hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(beat_position)
			&& $stable(beat_kind))
	else $error("stalled result changed");

	// Drop in_ready only behind a blocked result
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
	else $error("input stalled without output back-pressure");

	// A new result follows an accepted request
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
	else $error("result without a matching request");

	// A negative position only for onsets at the first three samples, checked as no lower than -4
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && beat_position[INDEX_WIDTH] |-> &beat_position[INDEX_WIDTH-1:2])
	else $error("beat position out of range");

endmodule

bind slope_qrs_detector sqrs_checker #(
	.SAMPLE_WIDTH(SAMPLE_WIDTH),
	.INDEX_WIDTH (INDEX_WIDTH)
) u_sqrs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.sample       (sample),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.beat_position(beat_position),
	.beat_kind    (beat_kind)
);
